// File: rtl/lda_pkg.sv
// Package for the Lorentzian density accumulator: word types, register map,
// fixed datapath widths and the control struct of the shared divider.
// No dependencies; every rtl file imports it.
package lda_pkg;

  // Fixed widths set by the word fields
  localparam int ENERGY_W   = 32;
  localparam int BROAD_W    = 31;
  localparam int KPT_W      = 16;
  localparam int DENS_W     = 32;
  localparam int ABS_W      = ENERGY_W + 1;      // |probe - eigen| below 2^32
  localparam int DEN_W      = 2 * ENERGY_W + 1;  // x^2 + d^2 below 2^65
  localparam int PI_W       = 34;
  localparam int MUL_A_W    = ABS_W;
  localparam int MUL_B_W    = PI_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int SUM_MAX_W  = 64;
  localparam int PROD_W     = SUM_MAX_W + PI_W;  // sum * pi before scaling
  localparam int HALF_W     = SUM_MAX_W / 2;

  // pi in Q2.32, rounded
  localparam logic [PI_W-1:0] PI_Q32 = 34'd13493037705;

  // Parameter defaults
  localparam int FRACTION_BITS_DEF = 20;
  localparam int SUM_WIDTH_DEF     = 64;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [BROAD_W-1:0] BROAD_RST = 31'd10486;
  localparam logic [KPT_W-1:0]   KPT_RST   = 16'd1;

  typedef enum logic [0:0] {
    REG_BROADENING = 1'b0,
    REG_KPOINT     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [BROAD_W-1:0] broadening;
    logic [KPT_W-1:0]   kpoint_count;
  } cfg_regs_t;

  // Channel words
  typedef struct packed {
    logic signed [ENERGY_W-1:0] probe_energy;
    logic signed [ENERGY_W-1:0] eigen_energy;
    logic                       last_item;
  } in_word_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              overflow;
  } out_word_t;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;   // take new operands, clear quotient
    logic step;   // one restoring step
    logic shift;  // shift a dividend bit into the remainder this step
  } div_ctl_t;

endpackage

// File: rtl/lda_regs.sv
// APB-style configuration registers: broadening and k-point count.
// Depends on lda_pkg.
module lda_regs
  import lda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  cfg_regs_t cfg_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register write, access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.broadening   <= BROAD_RST;
      cfg_r.kpoint_count <= KPT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_BROADENING: cfg_r.broadening   <= pwdata[BROAD_W-1:0];
        REG_KPOINT:     cfg_r.kpoint_count <= pwdata[KPT_W-1:0];
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_BROADENING: prdata = CFG_DW'(cfg_r.broadening);
      REG_KPOINT:     prdata = CFG_DW'(cfg_r.kpoint_count);
    endcase
  end

endmodule

// File: rtl/lda_mul.sv
// Shared unsigned multiplier with a registered product, used for x^2, d^2
// and the two halves of sum * pi. Depends on lda_pkg.
module lda_mul
  import lda_pkg::*;
(
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  logic [MUL_P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign p = p_r;

endmodule

// File: rtl/lda_div.sv
// Shared restoring radix-2 divider, one quotient bit per step.
// Serves the Lorentzian term and the final division by the k-point count.
// Depends on lda_pkg.
module lda_div
  import lda_pkg::*;
#(
  parameter int QW = 53,   // quotient bits kept
  parameter int PW = 50    // dividend bits shifted in
) (
  input  logic             clk,
  input  div_ctl_t         ctl,
  input  logic [DEN_W-1:0] ld_rem,
  input  logic [DEN_W-1:0] ld_den,
  input  logic [PW-1:0]    ld_dvd,
  output logic [QW-1:0]    quo
);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [PW-1:0]    dvd_r;
  logic [QW-1:0]    quo_r;

  logic [DEN_W:0]   rem2;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // partial remainder, trial subtract
  assign rem2 = ctl.shift ? {rem_r, dvd_r[PW-1]} : {1'b0, rem_r};
  assign diff = {1'b0, rem2} - {2'b00, den_r};
  assign ge   = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= ld_rem;
      den_r <= ld_den;
      dvd_r <= ld_dvd;
      quo_r <= '0;
    end else if (ctl.step) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      quo_r <= {quo_r[QW-2:0], ge};
      if (ctl.shift) begin
        dvd_r <= {dvd_r[PW-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_r;

endmodule

// File: rtl/lorentzian_density_accumulator_core.sv
// Lorentzian density accumulator, top level and sequencer. A word keeps in_ready low while its
// distance and the broadening are squared, the term is divided out by the radix-2 divider
// (skipped on a zero denominator) and added to the sum; a last word also holds it through pi
// scaling, the k-point division and, while an earlier result waits, the result stage. Synchronous
// active-low reset clears the sum, the saturation mark, the sequencer and the registers
// (broadening 10486, k-point count 1). Uses lda_pkg.
module lorentzian_density_accumulator_core
  import lda_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int SUM_WIDTH     = SUM_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int SUM_FRAC   = SUM_WIDTH / 2;
  localparam int TERM_STEPS = FRACTION_BITS + SUM_FRAC + 1;
  localparam int PW         = SUM_WIDTH + PI_W - SUM_FRAC - 16;
  localparam int QW         = (TERM_STEPS > PW) ? TERM_STEPS : PW;
  localparam int CW         = (QW > SUM_WIDTH) ? QW : SUM_WIDTH;
  localparam int CNT_W      = $clog2(QW + 1);
  localparam int SHR        = SUM_FRAC + 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,    // multiply |x| * |x|
    ST_SQD,    // multiply d * d, keep x^2
    ST_DEN,    // form denominator, load divider
    ST_DIVT,   // term division
    ST_ACC,    // saturating accumulate
    ST_MULH,   // sum high half * pi
    ST_MULL,   // sum low half * pi
    ST_FLD,    // form scaled product, load divider
    ST_DIVF,   // division by k-point count
    ST_FIN     // saturate and present result
  } state_t;

  state_t              state_r, state_nxt;
  logic [SUM_WIDTH-1:0] sum_r;
  logic                sat_r;
  logic                last_r;
  logic                zden_r;
  logic                first_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  out_word_t           out_data_r;
  logic [ABS_W-1:0]    ax_r;
  logic [DEN_W-1:0]    xsq_r;
  logic [MUL_P_W-2:0]  acc_r;

  cfg_regs_t           cfg;
  logic                in_acc;
  logic [ABS_W-1:0]    diff;
  logic [ABS_W-1:0]    ax;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [DEN_W-1:0]    den_sum;
  logic [63:0]         sum64;
  logic [MUL_P_W-2:0]  prod_hi;
  logic [PROD_W-1:0]   prod;
  logic [KPT_W-1:0]    kpt;
  div_ctl_t            div_ctl;
  logic [DEN_W-1:0]    ld_rem;
  logic [DEN_W-1:0]    ld_den;
  logic [PW-1:0]       ld_dvd;
  logic [QW-1:0]       quo;
  logic [SUM_WIDTH-1:0] term;
  logic [SUM_WIDTH:0]  sum_add;
  logic                fin_go;
  logic                res_sat;

  lda_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lda_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  lda_div #(
    .QW (QW),
    .PW (PW)
  ) u_div (
    .clk    (clk),
    .ctl    (div_ctl),
    .ld_rem (ld_rem),
    .ld_den (ld_den),
    .ld_dvd (ld_dvd),
    .quo    (quo)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // |probe - eigen|, exact in 33 bits
  assign diff = {in_data.probe_energy[ENERGY_W-1], in_data.probe_energy}
              - {in_data.eigen_energy[ENERGY_W-1], in_data.eigen_energy};
  assign ax   = diff[ABS_W-1] ? (~diff + 1'b1) : diff;

  // multiplier operand select
  assign sum64 = 64'(sum_r);
  always_comb begin
    unique case (state_r)
      ST_SQX: begin
        mul_a = ax_r;
        mul_b = MUL_B_W'(ax_r);
      end
      ST_SQD: begin
        mul_a = MUL_A_W'(cfg.broadening);
        mul_b = MUL_B_W'(cfg.broadening);
      end
      ST_MULH: begin
        mul_a = MUL_A_W'(sum64[63:HALF_W]);
        mul_b = PI_Q32;
      end
      ST_MULL: begin
        mul_a = MUL_A_W'(sum64[HALF_W-1:0]);
        mul_b = PI_Q32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // denominator and scaled product
  assign den_sum = xsq_r + mul_p[DEN_W-1:0];
  assign prod_hi = acc_r + (MUL_P_W-1)'(mul_p[MUL_P_W-1:HALF_W]);
  assign prod    = {prod_hi, mul_p[HALF_W-1:0]};
  assign kpt     = (cfg.kpoint_count == '0) ? KPT_W'(1) : cfg.kpoint_count;

  // divider control and operands
  always_comb begin
    div_ctl.load  = 1'b0;
    div_ctl.step  = (state_r == ST_DIVT) || (state_r == ST_DIVF);
    div_ctl.shift = !first_r;
    ld_rem        = DEN_W'(cfg.broadening);
    ld_den        = den_sum;
    ld_dvd        = '0;
    if (state_r == ST_DEN) begin
      div_ctl.load = (den_sum != '0);
    end else if (state_r == ST_FLD) begin
      div_ctl.load = 1'b1;
      ld_rem       = '0;
      ld_den       = DEN_W'(kpt);
      ld_dvd       = prod[SHR +: PW];
    end
  end

  // saturated term and sum
  always_comb begin
    if (zden_r || (CW'(quo) > CW'({SUM_WIDTH{1'b1}}))) begin
      term = {SUM_WIDTH{1'b1}};
    end else begin
      term = SUM_WIDTH'(quo);
    end
  end
  assign sum_add = {1'b0, sum_r} + {1'b0, term};
  assign res_sat = (quo[QW-1:DENS_W] != '0);
  assign fin_go  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQD;
      ST_SQD:  state_nxt = ST_DEN;
      ST_DEN:  state_nxt = (den_sum == '0) ? ST_ACC : ST_DIVT;
      ST_DIVT: if (cnt_r == CNT_W'(1)) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_MULH : ST_IDLE;
      ST_MULH: state_nxt = ST_MULL;
      ST_MULL: state_nxt = ST_FLD;
      ST_FLD:  state_nxt = ST_DIVF;
      ST_DIVF: if (cnt_r == CNT_W'(1)) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer state, accumulator and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      last_r      <= 1'b0;
      zden_r      <= 1'b0;
      first_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // a new result replaces one taken in the same cycle
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (in_acc) last_r <= in_data.last_item;
        ST_DEN: begin
          zden_r  <= (den_sum == '0);
          first_r <= 1'b1;
          cnt_r   <= CNT_W'(TERM_STEPS);
        end
        ST_DIVT, ST_DIVF: begin
          first_r <= 1'b0;
          cnt_r   <= cnt_r - 1'b1;
        end
        ST_ACC: begin
          sum_r <= sum_add[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_add[SUM_WIDTH-1:0];
          sat_r <= sat_r | sum_add[SUM_WIDTH] | zden_r;
        end
        ST_FLD: begin
          first_r <= 1'b0;
          cnt_r   <= CNT_W'(PW);
        end
        ST_FIN: begin
          if (fin_go) begin
            out_data_r.density   <= res_sat ? {DENS_W{1'b1}} : quo[DENS_W-1:0];
            out_data_r.overflow  <= sat_r | res_sat;
            sum_r                <= '0;
            sat_r                <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) ax_r <= ax;
    if (state_r == ST_SQD) xsq_r <= mul_p[DEN_W-1:0];
    if (state_r == ST_MULL) acc_r <= mul_p[MUL_P_W-2:0];
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a word is in progress");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (sum_r == '0) && !sat_r)
    else $error("sum or saturation mark not cleared after result");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVT || state_r == ST_DIVF) |-> (cnt_r != '0) && (cnt_r <= CNT_W'(QW)))
    else $error("divider step count out of range");

endmodule

// File: test/tb_lorentzian_density_accumulator_core.sv
`timescale 1ns / 100ps
// Testbench for lorentzian_density_accumulator_core: a directed table, then random eigenvalue
// sets, checked word by word against a bit-exact predictor kept in this file. Uses lda_pkg.
module tb_lorentzian_density_accumulator_core;
  import lda_pkg::*;

  localparam int FRAC_BITS = FRACTION_BITS_DEF;
  localparam int SUM_W     = SUM_WIDTH_DEF;
  localparam int SUM_FRAC  = SUM_W / 2;
  localparam logic [63:0] SUM_MAX = {64{1'b1}} >> (64 - SUM_W);
  localparam int DRAIN_CYCLES  = 150;     // covers a last word from accept to result
  localparam int CYCLE_LIMIT   = 500000;
  localparam int NUM_VECTORS   = 17;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_WORDS   = 105;

  // Directed stimulus row; a config write, when flagged, goes before the word
  typedef struct packed {
    logic        cfg;
    logic [31:0] broad_raw;
    logic [31:0] kpt_raw;
    logic [31:0] probe;
    logic [31:0] eigen;
    logic        last;
    logic        typed;
    logic [31:0] dens;
    logic        ovf;
  } vector_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Predictor state
  logic [BROAD_W-1:0] broadening_q;
  logic [KPT_W-1:0]   kpoint_q;
  logic [63:0]        density_sum_q;
  bit                 sum_saturated_q;

  out_word_t pending_densities[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        quiet = 1'b0;
  int        stall_left = 0;

  lorentzian_density_accumulator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Adds one Lorentzian term to the predicted sum; on a last word, forms the density
  function automatic void accumulate_lorentzian(input in_word_t w, output bit emits,
                                                output out_word_t res);
    logic [32:0]  diff;
    logic [32:0]  mag;
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] prod;
    logic [63:0]  term;
    logic [15:0]  kdiv;
    diff  = {w.probe_energy[31], w.probe_energy} - {w.eigen_energy[31], w.eigen_energy};
    mag   = diff[32] ? -diff : diff;
    den   = {95'd0, mag} * {95'd0, mag} + {97'd0, broadening_q} * {97'd0, broadening_q};
    num   = {97'd0, broadening_q} << (FRAC_BITS + SUM_FRAC);
    emits = 1'b0;
    res   = '0;
    // zero denominator counts as the largest term
    if (den == 128'd0) begin
      term = SUM_MAX;
      sum_saturated_q = 1'b1;
    end else begin
      quo  = num / den;
      term = (quo > {64'd0, SUM_MAX}) ? SUM_MAX : quo[63:0];
    end
    if (term > SUM_MAX - density_sum_q) begin
      density_sum_q   = SUM_MAX;
      sum_saturated_q = 1'b1;
    end else begin
      density_sum_q = density_sum_q + term;
    end
    if (!w.last_item) return;
    // pi scaling and k-point division; a zero count divides by one
    kdiv = (kpoint_q == '0) ? 16'd1 : kpoint_q;
    prod = ({64'd0, density_sum_q} * {94'd0, PI_Q32}) / {112'd0, kdiv};
    prod = prod >> (SUM_FRAC + 16);
    emits = 1'b1;
    if (prod > 128'hFFFF_FFFF) begin
      res.density  = 32'hFFFF_FFFF;
      res.overflow = 1'b1;
    end else begin
      res.density  = prod[31:0];
      res.overflow = sum_saturated_q;
    end
    density_sum_q   = '0;
    sum_saturated_q = 1'b0;
  endfunction

  function automatic vector_t vector_at(input int i);
    case (i)
      0:  return '{1'b0, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0};
      1:  return '{1'b0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'd0, 1'b0};
      2:  return '{1'b0, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0};
      // narrowest broadening, widest spacing: term truncates to zero
      3:  return '{1'b1, 32'd1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                   1'b1, 32'd0, 1'b0};
      // narrowest broadening on resonance: density saturates
      4:  return '{1'b0, 32'd0, 32'd0, 32'h0001_2345, 32'h0001_2345, 1'b1,
                   1'b1, 32'hFFFF_FFFF, 1'b1};
      // zero broadening with equal energies saturates the sum
      5:  return '{1'b1, 32'd0, 32'd1, 32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, 32'd0, 1'b0};
      6:  return '{1'b0, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0001, 1'b1,
                   1'b1, 32'hFFFF_FFFF, 1'b1};
      // mark cleared after emission, zero broadening off resonance adds nothing
      7:  return '{1'b0, 32'd0, 32'd0, 32'h0000_0007, 32'h0000_0009, 1'b1, 1'b1, 32'd0, 1'b0};
      // upper bit of the broadening write is dropped
      8:  return '{1'b1, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0,
                   1'b0, 32'd0, 1'b0};
      9:  return '{1'b0, 32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'd0, 1'b0};
      10: return '{1'b0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0, 1'b0};
      // zero k-point count
      11: return '{1'b1, 32'd10486, 32'd0, 32'h0010_0000, 32'hFFF0_0000, 1'b1,
                   1'b0, 32'd0, 1'b0};
      // upper half of the k-point write is dropped
      12: return '{1'b1, 32'h0010_0000, 32'hABCD_0003, 32'h0010_0000, 32'h0000_0000, 1'b0,
                   1'b0, 32'd0, 1'b0};
      13: return '{1'b0, 32'd0, 32'd0, 32'hFFF0_0000, 32'h0010_0000, 1'b0, 1'b0, 32'd0, 1'b0};
      14: return '{1'b0, 32'd0, 32'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'd0, 1'b0};
      15: return '{1'b1, 32'h0000_0400, 32'd1, 32'h0000_0000, 32'h0000_0000, 1'b1,
                   1'b0, 32'd0, 1'b0};
      default: return '{1'b1, 32'h4000_0000, 32'd65535, 32'h1234_5678, 32'hEDCB_A988, 1'b1,
                        1'b0, 32'd0, 1'b0};
    endcase
  endfunction

  // Register write then read-back; block must be idle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] want;
    want = (idx == REG_BROADENING) ? {1'b0, val[BROAD_W-1:0]} : {16'd0, val[KPT_W-1:0]};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_BROADENING) broadening_q = val[BROAD_W-1:0];
    else kpoint_q = val[KPT_W-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want)
      report_mismatch($sformatf("reg %0d read %h, want %h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all pending results, then let a non-last word finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_densities.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    int        gap;
    bit        emits;
    out_word_t res;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    accumulate_lorentzian(w, emits, res);
    if (emits) pending_densities.insert(pending_densities.size(), typed ? typed_res : res);
  endtask

  // Energy near a center, at the extremes, or anywhere
  function automatic logic [31:0] pick_energy(input logic [31:0] center);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return center + $urandom_range(0, 4095) - 2048;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: return center + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return center;
    endcase
  endfunction

  // Result side: random stall bursts, checking against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_densities.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h/%b", out_data.density,
                                  out_data.overflow));
      end else begin
        want = pending_densities.pop_front();
        if (out_data.density !== want.density)
          report_mismatch($sformatf("density %h, want %h", out_data.density, want.density));
        if (out_data.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_data.overflow,
                                    want.overflow));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(1, 7) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    vector_t     v;
    in_word_t    w;
    out_word_t   tr;
    logic [31:0] probe;
    int          set_len;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    broadening_q    = BROAD_RST;
    kpoint_q        = KPT_RST;
    density_sum_q   = '0;
    sum_saturated_q = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NUM_VECTORS; i++) begin
      v = vector_at(i);
      if (v.cfg) begin
        settle();
        write_reg(REG_BROADENING, v.broad_raw);
        write_reg(REG_KPOINT, v.kpt_raw);
      end
      w.probe_energy = v.probe;
      w.eigen_energy = v.eigen;
      w.last_item    = v.last;
      tr.density     = v.dens;
      tr.overflow    = v.ovf;
      send_word(w, v.typed, tr);
    end

    // Random phases, each under its own register setting; the last runs without idling
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 4))
        0: write_reg(REG_BROADENING, $urandom_range(1, 64));
        1: write_reg(REG_BROADENING, 32'd1 << $urandom_range(0, 30));
        2: write_reg(REG_BROADENING, 32'h7FFF_FFFF);
        3: write_reg(REG_BROADENING, $urandom);
        default: write_reg(REG_BROADENING, $urandom_range(5000, 2000000));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_KPOINT, 32'd1);
        1: write_reg(REG_KPOINT, 32'd65535);
        2: write_reg(REG_KPOINT, $urandom_range(1, 65535));
        default: write_reg(REG_KPOINT, $urandom);
      endcase
      if (ph == RANDOM_PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < PHASE_WORDS; ) begin
        set_len = $urandom_range(1, 8);
        probe   = pick_energy($urandom);
        for (int j = 0; j < set_len; j++) begin
          // mostly one probe per set; some noise in probe and last marker
          w.probe_energy = ($urandom_range(0, 9) == 0) ? pick_energy(probe) : probe;
          w.eigen_energy = pick_energy(probe);
          w.last_item    = (j == set_len - 1);
          if ($urandom_range(0, 19) == 0) w.last_item = ~w.last_item;
          send_word(w, 1'b0, '0);
          n++;
        end
      end
    end

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lda_pkg.sv
rtl/lda_regs.sv
rtl/lda_mul.sv
rtl/lda_div.sv
rtl/lorentzian_density_accumulator_core.sv
test/tb_lorentzian_density_accumulator_core.sv
